### hw/rtl/pps_chk_pkg.sv
package pps_chk_pkg;

    localparam logic [7:0] PPSS_BYTE   = 8'hFF;
    localparam logic [7:0] FMT_MASK    = 8'h9F;
    localparam logic [7:0] FMT_T0_PPS1 = 8'h10;
    localparam logic [7:0] FIDI_RESET  = 8'h96;
    localparam logic [7:0] FAIL_MID    = 8'h00;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index taken from the word address
    localparam logic REG_ACCEPTED_FIDI = 1'b0;

    // reply byte positions
    localparam logic [1:0] POS_PPSS  = 2'd0;
    localparam logic [1:0] POS_PPS0  = 2'd1;
    localparam logic [1:0] POS_PPS1  = 2'd2;
    localparam logic [1:0] POS_PCK   = 2'd3;

    typedef struct packed {
        logic       load;
        logic       acc;
        logic [7:0] fidi;
    } reply_req_t;

endpackage

### hw/rtl/pps_chk_ifs.sv
interface pps_chk_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       first;

    modport source (output valid, output rx_byte, output first, input ready);
    modport sink (input valid, input rx_byte, input first, output ready);
endinterface

interface pps_chk_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       accepted;
    logic [7:0] new_fidi;

    modport source (output valid, output tx_byte, output tx_last, output accepted,
                    output new_fidi, input ready);
    modport sink (input valid, input tx_byte, input tx_last, input accepted,
                  input new_fidi, output ready);
endinterface

### hw/rtl/pps_chk_reply.sv
module pps_chk_reply
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pps_chk_pkg::reply_req_t req,
    output logic                    busy,
    pps_chk_tx_if.source            tx
);

    logic       active_reg;
    logic [1:0] idx_reg;
    logic       acc_reg;
    logic [7:0] fidi_reg;
    logic       last_byte;
    logic       take;

    assign busy = active_reg;
    assign take = tx.valid && tx.ready;

    // accepting reply has four bytes, failure reply three
    assign last_byte = acc_reg ? (idx_reg == pps_chk_pkg::POS_PCK)
                               : (idx_reg == pps_chk_pkg::POS_PPS1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 2'd0;
        end
        else if (req.load)
        begin
            active_reg <= 1'b1;
            idx_reg    <= pps_chk_pkg::POS_PPSS;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                active_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            acc_reg  <= req.acc;
            fidi_reg <= req.fidi;
        end
    end

    always_comb
    begin
        tx.tx_byte = pps_chk_pkg::PPSS_BYTE;
        case (idx_reg)
            pps_chk_pkg::POS_PPSS: tx.tx_byte = pps_chk_pkg::PPSS_BYTE;
            pps_chk_pkg::POS_PPS0: tx.tx_byte = acc_reg ? pps_chk_pkg::FMT_T0_PPS1
                                                        : pps_chk_pkg::FAIL_MID;
            pps_chk_pkg::POS_PPS1: tx.tx_byte = acc_reg ? fidi_reg
                                                        : pps_chk_pkg::PPSS_BYTE;
            pps_chk_pkg::POS_PCK:  tx.tx_byte = pps_chk_pkg::PPSS_BYTE
                                                ^ pps_chk_pkg::FMT_T0_PPS1 ^ fidi_reg;
            default:               tx.tx_byte = pps_chk_pkg::PPSS_BYTE;
        endcase
    end

    assign tx.valid    = active_reg;
    assign tx.tx_last  = last_byte;
    assign tx.accepted = acc_reg;
    assign tx.new_fidi = acc_reg ? fidi_reg : 8'h00;

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.load |-> !active_reg)
        else $error("reply loaded while previous reply still open");

    a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !acc_reg) |-> (idx_reg != pps_chk_pkg::POS_PCK))
        else $error("failure reply ran past three bytes");

    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> $past(tx.tx_last && tx.ready))
        else $error("reply closed before its last byte was taken");

endmodule

### hw/rtl/pps_request_checker_unit.sv
// PPS request checker, card side. Request bytes following PPSS (PPS0 first, marked by
// first) enter on rx at up to one per cycle and are registered, then checked in a single
// pass: running XOR, format and FiDi compare against accepted_fidi. A request with a bad
// check byte is dropped silently; otherwise the reply (FF 10 PPS1 PCK, or FF 00 FF on
// refusal) leaves on tx one byte per cycle while tx is ready. There is one reply slot:
// the byte that closes a request waits in the input register while an earlier reply is
// still going out, which holds rx.ready low until that reply's last byte has been taken,
// including any tx stall.
// accepted_fidi sits at APB address 0 and resets to 0x96.
module pps_request_checker_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    pps_chk_rx_if.sink                      rx,
    pps_chk_tx_if.source                    tx,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pps_chk_pkg::APB_AW-1:0]  paddr,
    input  logic [pps_chk_pkg::APB_DW-1:0]  pwdata,
    output logic [pps_chk_pkg::APB_DW-1:0]  prdata,
    output logic                            pready
);

    logic       accepted_fidi_hit;
    logic [7:0] fidi_cfg_reg;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;

    logic [2:0] bytes_left_reg, bytes_left_next;
    logic [7:0] xor_sum_reg, xor_sum_next;
    logic [7:0] saved_format_reg, saved_format_next;
    logic [7:0] saved_first_param_reg, saved_first_param_next;
    logic [1:0] param_index_reg, param_index_next;

    logic       closes_ok;
    logic       advance;
    logic       reply_busy;
    logic [7:0] xor_acc;
    logic [2:0] left_dec;

    pps_chk_pkg::reply_req_t reply_req;

    // configuration
    assign pready = 1'b1;
    assign accepted_fidi_hit = (paddr[2] == pps_chk_pkg::REG_ACCEPTED_FIDI);
    assign prdata = accepted_fidi_hit ? {24'h0, fidi_cfg_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fidi_cfg_reg <= pps_chk_pkg::FIDI_RESET;
        end
        else if (psel && penable && pwrite && accepted_fidi_hit)
        begin
            fidi_cfg_reg <= pwdata[7:0];
        end
    end

    // input register
    assign rx.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_vld_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg  <= rx.rx_byte;
            in_first_reg <= rx.first;
        end
    end

    // request check
    assign xor_acc  = xor_sum_reg ^ in_byte_reg;
    assign left_dec = bytes_left_reg - 3'd1;

    always_comb
    begin
        bytes_left_next        = bytes_left_reg;
        xor_sum_next           = xor_sum_reg;
        saved_format_next      = saved_format_reg;
        saved_first_param_next = saved_first_param_reg;
        param_index_next       = param_index_reg;
        closes_ok              = 1'b0;
        if (in_first_reg)
        begin
            bytes_left_next        = 3'd1 + {2'b0, in_byte_reg[4]} + {2'b0, in_byte_reg[5]}
                                     + {2'b0, in_byte_reg[6]};
            xor_sum_next           = pps_chk_pkg::PPSS_BYTE ^ in_byte_reg;
            saved_format_next      = in_byte_reg;
            saved_first_param_next = 8'h00;
            param_index_next       = 2'd0;
        end
        else if (bytes_left_reg != 3'd0)
        begin
            xor_sum_next    = xor_acc;
            bytes_left_next = left_dec;
            if (param_index_reg == 2'd0)
            begin
                saved_first_param_next = in_byte_reg;
            end
            if (param_index_reg != 2'd3)
            begin
                param_index_next = param_index_reg + 2'd1;
            end
            if (left_dec == 3'd0)
            begin
                xor_sum_next = pps_chk_pkg::PPSS_BYTE;
                closes_ok    = (xor_acc == 8'h00);
            end
        end
    end

    assign advance = in_vld_reg && (!closes_ok || !reply_busy);

    assign reply_req.load = advance && closes_ok;
    assign reply_req.acc  = ((saved_format_reg & pps_chk_pkg::FMT_MASK)
                             == pps_chk_pkg::FMT_T0_PPS1)
                            && (saved_first_param_next == fidi_cfg_reg);
    assign reply_req.fidi = saved_first_param_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg        <= 3'd0;
            xor_sum_reg           <= pps_chk_pkg::PPSS_BYTE;
            saved_format_reg      <= 8'h00;
            saved_first_param_reg <= 8'h00;
            param_index_reg       <= 2'd0;
        end
        else if (advance)
        begin
            bytes_left_reg        <= bytes_left_next;
            xor_sum_reg           <= xor_sum_next;
            saved_format_reg      <= saved_format_next;
            saved_first_param_reg <= saved_first_param_next;
            param_index_reg       <= param_index_next;
        end
    end

    pps_chk_reply u_reply
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (reply_req),
        .busy  (reply_busy),
        .tx    (tx)
    );

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= 3'd4)
        else $error("bytes_left out of range");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        reply_req.load |=> (bytes_left_reg == 3'd0 && xor_sum_reg == pps_chk_pkg::PPSS_BYTE))
        else $error("request not closed after reply load");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_byte_reg)
                                      && $stable(in_first_reg)))
        else $error("stalled request byte lost");

endmodule

### sim/tb_pps_request_checker_unit.sv
`timescale 1ns / 1ps

module tb_pps_request_checker_unit;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 80;
    localparam int PHASE_ITEMS   = 64;
    localparam logic [pps_chk_pkg::APB_AW-1:0] FIDI_ADDR =
        pps_chk_pkg::APB_AW'(4 * int'(pps_chk_pkg::REG_ACCEPTED_FIDI));

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_e;

    typedef enum logic [1:0] {
        OUT_MODEL,
        OUT_SILENT,
        OUT_REFUSE,
        OUT_GRANT
    } outcome_e;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       accepted;
        logic [7:0] new_fidi;
    } reply_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       first;
        outcome_e   kind;
        logic [7:0] fidi;
        logic [7:0] pck;
    } plan_row_t;

    // fixed reply rows assume accepted_fidi at its reset value
    localparam plan_row_t PLAN [24] = '{
        '{8'h00, 1'b0, OUT_SILENT, 8'h00, 8'h00},   // byte while idle
        '{8'h10, 1'b1, OUT_MODEL,  8'h00, 8'h00},
        '{8'h96, 1'b0, OUT_MODEL,  8'h00, 8'h00},
        '{8'h79, 1'b0, OUT_GRANT,  8'h96, 8'h79},
        '{8'h00, 1'b1, OUT_MODEL,  8'h00, 8'h00},   // no pps1
        '{8'hFF, 1'b0, OUT_REFUSE, 8'h00, 8'h00},
        '{8'h10, 1'b1, OUT_MODEL,  8'h00, 8'h00},
        '{8'h96, 1'b0, OUT_MODEL,  8'h00, 8'h00},
        '{8'h00, 1'b0, OUT_SILENT, 8'h00, 8'h00},   // bad check byte
        '{8'h70, 1'b1, OUT_MODEL,  8'h00, 8'h00},
        '{8'h96, 1'b0, OUT_MODEL,  8'h00, 8'h00},
        '{8'h10, 1'b1, OUT_MODEL,  8'h00, 8'h00},   // restart mid-request
        '{8'h96, 1'b0, OUT_MODEL,  8'h00, 8'h00},
        '{8'h79, 1'b0, OUT_GRANT,  8'h96, 8'h79},
        '{8'h70, 1'b1, OUT_MODEL,  8'h00, 8'h00},   // pps1..pps3 present
        '{8'h96, 1'b0, OUT_MODEL,  8'h00, 8'h00},
        '{8'h00, 1'b0, OUT_MODEL,  8'h00, 8'h00},
        '{8'h00, 1'b0, OUT_MODEL,  8'h00, 8'h00},
        '{8'h19, 1'b0, OUT_GRANT,  8'h96, 8'h79},
        '{8'hFF, 1'b1, OUT_MODEL,  8'h00, 8'h00},   // all ones
        '{8'hFF, 1'b0, OUT_MODEL,  8'h00, 8'h00},
        '{8'hFF, 1'b0, OUT_MODEL,  8'h00, 8'h00},
        '{8'hFF, 1'b0, OUT_MODEL,  8'h00, 8'h00},
        '{8'hFF, 1'b0, OUT_REFUSE, 8'h00, 8'h00}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [pps_chk_pkg::APB_AW-1:0]    paddr;
    logic [pps_chk_pkg::APB_DW-1:0]    pwdata;
    logic [pps_chk_pkg::APB_DW-1:0]    prdata;
    logic                              pready;

    pps_chk_rx_if rx();
    pps_chk_tx_if tx();

    pps_request_checker_unit dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .tx      (tx),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // checker state
    logic [7:0] fidi_reg;
    logic [2:0] chk_left;
    logic [7:0] chk_xor;
    logic [7:0] chk_pps0;
    logic [7:0] chk_pps1;
    logic [1:0] chk_count;

    reply_t     pending_replies[$];
    idle_mode_e idle_mode = IDLE_NONE;
    int         fault_count = 0;
    int         live_items = 0;
    int         hold_req_cnt = 0;
    int         cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void make_reply(input bit acc, input logic [7:0] fidi,
                                       input logic [7:0] pck, output reply_t rep[$]);
        rep = {};
        if (acc)
        begin
            rep.push_back(reply_t'{pps_chk_pkg::PPSS_BYTE, 1'b0, 1'b1, fidi});
            rep.push_back(reply_t'{pps_chk_pkg::FMT_T0_PPS1, 1'b0, 1'b1, fidi});
            rep.push_back(reply_t'{fidi, 1'b0, 1'b1, fidi});
            rep.push_back(reply_t'{pck, 1'b1, 1'b1, fidi});
        end
        else
        begin
            rep.push_back(reply_t'{pps_chk_pkg::PPSS_BYTE, 1'b0, 1'b0, 8'h00});
            rep.push_back(reply_t'{pps_chk_pkg::FAIL_MID, 1'b0, 1'b0, 8'h00});
            rep.push_back(reply_t'{pps_chk_pkg::PPSS_BYTE, 1'b1, 1'b0, 8'h00});
        end
    endfunction

    function automatic void clear_checker();
        fidi_reg  = pps_chk_pkg::FIDI_RESET;
        chk_left  = 3'd0;
        chk_xor   = pps_chk_pkg::PPSS_BYTE;
        chk_pps0  = 8'h00;
        chk_pps1  = 8'h00;
        chk_count = 2'd0;
    endfunction

    // one request byte in, reply bytes out
    function automatic void answer_request(input logic [7:0] b, input logic f,
                                           output reply_t rep[$]);
        int n;
        rep = {};
        if (f)
        begin
            n = 1 + int'(b[4]) + int'(b[5]) + int'(b[6]);
            chk_left  = 3'(n);
            chk_xor   = pps_chk_pkg::PPSS_BYTE ^ b;
            chk_pps0  = b;
            chk_pps1  = 8'h00;
            chk_count = 2'd0;
            return;
        end
        if (chk_left == 3'd0)
            return;
        chk_xor = chk_xor ^ b;
        if (chk_count == 2'd0)
            chk_pps1 = b;
        if (chk_count != 2'd3)
            chk_count = chk_count + 2'd1;
        chk_left = chk_left - 3'd1;
        if (chk_left != 3'd0)
            return;
        if (chk_xor != 8'h00)
        begin
            chk_xor = pps_chk_pkg::PPSS_BYTE;
            return;
        end
        chk_xor = pps_chk_pkg::PPSS_BYTE;
        if ((chk_pps0 & pps_chk_pkg::FMT_MASK) == pps_chk_pkg::FMT_T0_PPS1
            && chk_pps1 == fidi_reg)
            make_reply(1'b1, chk_pps1,
                       pps_chk_pkg::PPSS_BYTE ^ pps_chk_pkg::FMT_T0_PPS1 ^ chk_pps1, rep);
        else
            make_reply(1'b0, 8'h00, 8'h00, rep);
    endfunction

    function automatic void note_fault(input string what, input reply_t want,
                                       input reply_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%s: expected byte %h last %b acc %b fidi %h, %s %h last %b acc %b fidi %h",
                     what, want.tx_byte, want.tx_last, want.accepted, want.new_fidi,
                     "got byte", got.tx_byte, got.tx_last, got.accepted, got.new_fidi);
    endfunction

    // reply side: check, then decide ready for the next edge
    initial
    begin
        int     hold_left;
        int     hold_seen;
        reply_t got;
        reply_t want;
        hold_left = 0;
        hold_seen = 0;
        tx.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && tx.valid && tx.ready)
            begin
                got = '{tx.tx_byte, tx.tx_last, tx.accepted, tx.new_fidi};
                if (pending_replies.size() == 0)
                    note_fault("unexpected reply byte", '0, got);
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.tx_byte !== want.tx_byte || got.tx_last !== want.tx_last ||
                        got.accepted !== want.accepted || got.new_fidi !== want.new_fidi)
                        note_fault("reply mismatch", want, got);
                end
            end
            if (hold_left == 0 && hold_seen != hold_req_cnt)
            begin
                hold_seen++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tx.ready <= 1'b0;
            end
            else if (idle_mode == IDLE_SINK || idle_mode == IDLE_BOTH)
                tx.ready <= ($urandom_range(99) >= 69);
            else
                tx.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f, input outcome_e kind,
                             input logic [7:0] fidi, input logic [7:0] pck);
        reply_t rep[$];
        int     gap;
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        rx.first   <= f;
        do
            @(posedge clk);
        while (!rx.ready);
        if (f || chk_left != 3'd0)
            live_items++;
        answer_request(b, f, rep);
        case (kind)
            OUT_SILENT: rep = {};
            OUT_REFUSE: make_reply(1'b0, 8'h00, 8'h00, rep);
            OUT_GRANT:  make_reply(1'b1, fidi, pck, rep);
            default: ;
        endcase
        foreach (rep[i])
            pending_replies.push_back(rep[i]);
        gap = 0;
        if (idle_mode == IDLE_SRC || idle_mode == IDLE_BOTH)
            while ($urandom_range(99) < 69)
                gap++;
        if (gap > 0)
        begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // mostly well-formed requests, some cut short, some stray bytes
    task automatic send_random_request();
        int         pick;
        int         n;
        int         stop;
        logic [7:0] pps0;
        logic [7:0] p;
        logic [7:0] sum;
        pick = $urandom_range(99);
        if (pick >= 85)
        begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), OUT_MODEL, 8'h00, 8'h00);
            return;
        end
        if ($urandom_range(4) == 0)
            pps0 = 8'($urandom_range(255));
        else
            pps0 = pps_chk_pkg::FMT_T0_PPS1 | 8'($urandom_range(3) << 5);
        n = int'(pps0[4]) + int'(pps0[5]) + int'(pps0[6]);
        stop = (pick >= 70) ? $urandom_range(n) : n + 1;
        sum = pps_chk_pkg::PPSS_BYTE ^ pps0;
        send_byte(pps0, 1'b1, OUT_MODEL, 8'h00, 8'h00);
        for (int k = 0; k < n && k < stop; k++)
        begin
            if (k == 0 && $urandom_range(3) != 0)
                p = fidi_reg;
            else
                p = 8'($urandom_range(255));
            sum = sum ^ p;
            send_byte(p, 1'b0, OUT_MODEL, 8'h00, 8'h00);
        end
        if (stop <= n)
            return;
        if ($urandom_range(6) == 0)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum, 1'b0, OUT_MODEL, 8'h00, 8'h00);
    endtask

    task automatic run_phase(input idle_mode_e mode, input int count);
        int start;
        bit held;
        idle_mode = mode;
        start = live_items;
        held = 1'b0;
        while (live_items - start < count)
        begin
            if (mode == IDLE_NONE && !held && live_items - start >= 12)
            begin
                hold_req_cnt++;
                held = 1'b1;
            end
            send_random_request();
        end
    endtask

    // wait for every reply, then let a silently dropped request clear the block
    task automatic settle();
        rx.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [pps_chk_pkg::APB_AW-1:0] addr,
                             input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= pps_chk_pkg::APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fidi_reg = value;
    endtask

    initial
    begin
        idle_mode_e modes [4];
        logic [7:0] fidis [4];
        modes = '{IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH};
        fidis = '{8'h00, 8'hFF, 8'($urandom_range(255)), pps_chk_pkg::FIDI_RESET};
        rst_n      <= 1'b0;
        rx.valid   <= 1'b0;
        rx.rx_byte <= 8'h00;
        rx.first   <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        clear_checker();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
            send_byte(PLAN[i].rx_byte, PLAN[i].first, PLAN[i].kind, PLAN[i].fidi, PLAN[i].pck);

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            apb_write(FIDI_ADDR, fidis[ph]);
            run_phase(modes[ph], PHASE_ITEMS);
        end
        settle();

        if (fault_count == 0 && pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
